/* rtl/core/sss_pkg.sv */
// Shared widths and defaults for the sample stream statistics block.
package sss_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 32;

    // Fixed widths of the reported totals
    localparam int SUM_BITS      = 48;
    localparam int SQ_BITS       = 63;
    localparam int ABS_BITS      = 48;
    localparam int OUT_CNT_BITS  = 32;

endpackage

/* rtl/core/sss_sample_if.sv */
// Input channel: one signed sample per transaction with an end-of-stream flag.
interface sss_sample_if
    import sss_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

/* rtl/core/sss_stats_if.sv */
// Result channel: one transaction of stream totals per finished stream.
interface sss_stats_if
    import sss_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] amp_min;
    logic signed [SAMPLE_BITS-1:0] amp_max;
    logic signed [SUM_BITS-1:0]    amp_sum;
    logic        [SQ_BITS-1:0]     square_sum;
    logic signed [SAMPLE_BITS:0]   step_min;
    logic signed [SAMPLE_BITS:0]   step_max;
    logic        [ABS_BITS-1:0]    abs_step_sum;
    logic        [OUT_CNT_BITS-1:0] zero_crossings;
    logic        [OUT_CNT_BITS-1:0] extrema_count;
    logic        [OUT_CNT_BITS-1:0] sample_count;

    modport source (
        output valid, output amp_min, output amp_max, output amp_sum,
        output square_sum, output step_min, output step_max, output abs_step_sum,
        output zero_crossings, output extrema_count, output sample_count,
        input ready
    );
    modport sink (
        input valid, input amp_min, input amp_max, input amp_sum,
        input square_sum, input step_min, input step_max, input abs_step_sum,
        input zero_crossings, input extrema_count, input sample_count,
        output ready
    );
endinterface

/* rtl/core/sample_stream_statistics.sv */
// Sample stream statistics: running min/max, sums, step range, crossings, extrema.
//
// Takes one sample per clock, continuously, as long as the result channel is not
// holding a stream's totals back. A sample passes an input register, a squaring
// stage (one SAMPLE_BITS x SAMPLE_BITS multiplier) and the accumulate stage, so the
// totals of a stream are registered as its last sample is accumulated. The
// statistics state is cleared in the same cycle, so the next stream may follow
// without a gap. Sums and counts saturate; counts are COUNT_BITS wide internally
// and reported in their low 32 bits. For a single-sample stream the step range
// reads back as its empty values (+/-(2^SAMPLE_BITS-1)).
module sample_stream_statistics
    import sss_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    sss_sample_if.sink   samples,
    sss_stats_if.source  stats
);

    localparam int SB = SAMPLE_BITS;

    localparam logic signed [SB-1:0] AMP_MIN_INIT  = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] AMP_MAX_INIT  = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB:0]   STEP_MIN_INIT = {1'b0, {SB{1'b1}}};
    localparam logic signed [SB:0]   STEP_MAX_INIT = {1'b1, {(SB-1){1'b0}}, 1'b1};

    // ---------------- pipeline control ----------------
    logic v1_reg, v2_reg, out_valid_reg;
    logic last2_reg;
    logic consume3, load2, in_ready;

    assign consume3 = v2_reg && (!last2_reg || !out_valid_reg || stats.ready);
    assign load2    = !v2_reg || consume3;
    assign in_ready = !v1_reg || load2;
    assign samples.ready = in_ready;

    // ---------------- stage 1: input register ----------------
    logic signed [SB-1:0] sample1_reg;
    logic                 last1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v1_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && samples.valid)
        begin
            sample1_reg <= samples.sample;
            last1_reg   <= samples.last;
        end
    end

    // ---------------- stage 2: square ----------------
    logic signed [2*SB-1:0] sq_prod;
    logic signed [SB-1:0]   sample2_reg;
    logic [SQ_BITS-1:0]     sq2_reg;

    assign sq_prod = sample1_reg * sample1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (load2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2 && v1_reg)
        begin
            sample2_reg <= sample1_reg;
            last2_reg   <= last1_reg;
            sq2_reg     <= SQ_BITS'($unsigned(sq_prod));
        end
    end

    // ---------------- stage 3: accumulate ----------------
    logic signed [SB-1:0]       min_reg, max_reg, prev_reg, older_reg;
    logic signed [SUM_BITS-1:0] sum_reg;
    logic [SQ_BITS-1:0]         sq_sum_reg;
    logic signed [SB:0]         step_min_reg, step_max_reg;
    logic [ABS_BITS-1:0]        abs_sum_reg;
    logic [COUNT_BITS-1:0]      cross_reg, turn_reg, count_reg;

    logic signed [SB-1:0]       min_next, max_next, older_next;
    logic signed [SUM_BITS-1:0] sum_next;
    logic [SQ_BITS-1:0]         sq_sum_next;
    logic signed [SB:0]         step_min_next, step_max_next;
    logic [ABS_BITS-1:0]        abs_sum_next;
    logic [COUNT_BITS-1:0]      cross_next, turn_next, count_next;

    logic signed [SB:0]         step;
    logic [SB-1:0]              abs_step;
    logic signed [SUM_BITS:0]   sum_wide;
    logic [SQ_BITS:0]           sq_wide;
    logic [ABS_BITS:0]          abs_wide;
    logic                       is_cross, is_turn;

    always_comb
    begin
        step     = (SB+1)'(sample2_reg) - (SB+1)'(prev_reg);
        abs_step = step[SB] ? SB'(-step) : step[SB-1:0];

        min_next = (sample2_reg < min_reg) ? sample2_reg : min_reg;
        max_next = (sample2_reg > max_reg) ? sample2_reg : max_reg;

        sum_wide = (SUM_BITS+1)'(sum_reg) + (SUM_BITS+1)'(sample2_reg);
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
            sum_next = {sum_wide[SUM_BITS], {(SUM_BITS-1){~sum_wide[SUM_BITS]}}};
        else
            sum_next = sum_wide[SUM_BITS-1:0];

        sq_wide     = {1'b0, sq_sum_reg} + {1'b0, sq2_reg};
        sq_sum_next = sq_wide[SQ_BITS] ? {SQ_BITS{1'b1}} : sq_wide[SQ_BITS-1:0];

        abs_wide     = {1'b0, abs_sum_reg} + (ABS_BITS+1)'(abs_step);
        abs_sum_next = abs_wide[ABS_BITS] ? {ABS_BITS{1'b1}} : abs_wide[ABS_BITS-1:0];

        // step range only once a previous sample exists
        step_min_next = step_min_reg;
        step_max_next = step_max_reg;
        if (count_reg != '0)
        begin
            if (step < step_min_reg) step_min_next = step;
            if (step > step_max_reg) step_max_next = step;
        end

        is_cross = (prev_reg < 0 && sample2_reg >= 0) || (prev_reg > 0 && sample2_reg <= 0);
        is_turn  = (older_reg < prev_reg && prev_reg > sample2_reg)
                || (older_reg > prev_reg && prev_reg < sample2_reg);

        cross_next = (is_cross && !(&cross_reg)) ? cross_reg + 1'b1 : cross_reg;
        turn_next  = (is_turn && !(&turn_reg)) ? turn_reg + 1'b1 : turn_reg;
        count_next = (&count_reg) ? count_reg : count_reg + 1'b1;

        // older neighbor follows only on change, which skips plateaus
        older_next = (sample2_reg != prev_reg) ? prev_reg : older_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg      <= AMP_MIN_INIT;
            max_reg      <= AMP_MAX_INIT;
            sum_reg      <= '0;
            sq_sum_reg   <= '0;
            step_min_reg <= STEP_MIN_INIT;
            step_max_reg <= STEP_MAX_INIT;
            abs_sum_reg  <= '0;
            cross_reg    <= '0;
            turn_reg     <= '0;
            count_reg    <= '0;
            prev_reg     <= '0;
            older_reg    <= '0;
        end
        else if (consume3)
        begin
            if (last2_reg)
            begin
                min_reg      <= AMP_MIN_INIT;
                max_reg      <= AMP_MAX_INIT;
                sum_reg      <= '0;
                sq_sum_reg   <= '0;
                step_min_reg <= STEP_MIN_INIT;
                step_max_reg <= STEP_MAX_INIT;
                abs_sum_reg  <= '0;
                cross_reg    <= '0;
                turn_reg     <= '0;
                count_reg    <= '0;
                prev_reg     <= '0;
                older_reg    <= '0;
            end
            else
            begin
                min_reg      <= min_next;
                max_reg      <= max_next;
                sum_reg      <= sum_next;
                sq_sum_reg   <= sq_sum_next;
                step_min_reg <= step_min_next;
                step_max_reg <= step_max_next;
                abs_sum_reg  <= abs_sum_next;
                cross_reg    <= cross_next;
                turn_reg     <= turn_next;
                count_reg    <= count_next;
                prev_reg     <= sample2_reg;
                older_reg    <= older_next;
            end
        end
    end

    // ---------------- result register ----------------
    logic signed [SB-1:0]       res_min_reg, res_max_reg;
    logic signed [SUM_BITS-1:0] res_sum_reg;
    logic [SQ_BITS-1:0]         res_sq_reg;
    logic signed [SB:0]         res_step_min_reg, res_step_max_reg;
    logic [ABS_BITS-1:0]        res_abs_reg;
    logic [OUT_CNT_BITS-1:0]    res_cross_reg, res_turn_reg, res_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (consume3 && last2_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (stats.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume3 && last2_reg)
        begin
            res_min_reg      <= min_next;
            res_max_reg      <= max_next;
            res_sum_reg      <= sum_next;
            res_sq_reg       <= sq_sum_next;
            res_step_min_reg <= step_min_next;
            res_step_max_reg <= step_max_next;
            res_abs_reg      <= abs_sum_next;
            res_cross_reg    <= OUT_CNT_BITS'(cross_next);
            res_turn_reg     <= OUT_CNT_BITS'(turn_next);
            res_count_reg    <= OUT_CNT_BITS'(count_next);
        end
    end

    assign stats.valid          = out_valid_reg;
    assign stats.amp_min        = res_min_reg;
    assign stats.amp_max        = res_max_reg;
    assign stats.amp_sum        = res_sum_reg;
    assign stats.square_sum     = res_sq_reg;
    assign stats.step_min       = res_step_min_reg;
    assign stats.step_max       = res_step_max_reg;
    assign stats.abs_step_sum   = res_abs_reg;
    assign stats.zero_crossings = res_cross_reg;
    assign stats.extrema_count  = res_turn_reg;
    assign stats.sample_count   = res_count_reg;

    // ---------------- assertions ----------------
    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (consume3 && last2_reg) |=> stats.valid)
        else $error("stream end did not produce a result");

    a_cleared_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (consume3 && last2_reg) |=> (count_reg == '0 && sum_reg == '0))
        else $error("statistics not cleared after stream end");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (consume3 && !last2_reg && !(&count_reg)) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("sample count did not advance");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("minimum above maximum");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> (v1_reg && v2_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");

endmodule

/* bench/tb_sample_stream_statistics.sv */
`timescale 1ns / 1ps
// Testbench for sample_stream_statistics: random streams checked against a running predictor.
module tb_sample_stream_statistics
    import sss_pkg::*;
;

    localparam int     SAMPLE_W    = 16;
    localparam longint SUM_HI      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO      = -SUM_HI - 1;
    localparam longint SQ_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ABS_MAX     = 64'sh0000_FFFF_FFFF_FFFF;
    localparam longint COUNT_MAX   = 64'sh0000_0000_FFFF_FFFF;
    localparam longint STEP_EMPTY  = 65535;
    localparam int     TARGET_ITEMS = 1250;
    localparam int     LONG_HOLD   = 300;

    typedef enum int {FULL_RANGE, NEAR_ZERO, WALK, RAILS} stream_kind_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        bit                         drain;   // wait for all totals before offering
    } sample_item_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] amp_min;
        logic signed [SAMPLE_W-1:0] amp_max;
        logic signed [SUM_BITS-1:0] amp_sum;
        logic [SQ_BITS-1:0]         square_sum;
        logic signed [SAMPLE_W:0]   step_min;
        logic signed [SAMPLE_W:0]   step_max;
        logic [ABS_BITS-1:0]        abs_step_sum;
        logic [OUT_CNT_BITS-1:0]    zero_crossings;
        logic [OUT_CNT_BITS-1:0]    extrema_count;
        logic [OUT_CNT_BITS-1:0]    sample_count;
    } stream_totals_t;

    logic clk = 1'b0;
    logic rst_n;

    sss_sample_if #(.SAMPLE_BITS(SAMPLE_W)) samples_ch ();
    sss_stats_if  #(.SAMPLE_BITS(SAMPLE_W)) stats_ch ();

    sample_stream_statistics #(.SAMPLE_BITS(SAMPLE_W)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .stats   (stats_ch)
    );

    always #5 clk = ~clk;

    sample_item_t   sample_queue[$];
    stream_totals_t totals_q[$];
    sample_item_t   next_item;
    stream_totals_t want;
    int             error_count = 0;
    int             results_seen = 0;
    int             item_total = 0;
    int             send_gap = 0;
    int             stall_left = 0;
    int             hold_left = 0;
    int             holds_done = 0;
    logic [9:0]     cycle_no = '0;
    logic           calm;

    // running statistics of the open stream
    longint amp_lo, amp_hi, amp_total, energy_total, step_lo, step_hi, travel_total;
    longint crossings, turns, n_samples, prev_s, pivot_s;

    // a quiet stretch every so often: no gaps and no stalls on either side
    assign calm = (cycle_no[9:7] == 3'b000);

    function automatic longint sat_inc(longint c);
        return (c < COUNT_MAX) ? c + 1 : COUNT_MAX;
    endfunction

    function automatic void clear_stream();
        amp_lo       = 32767;
        amp_hi       = -32768;
        amp_total    = 0;
        energy_total = 0;
        step_lo      = STEP_EMPTY;
        step_hi      = -STEP_EMPTY;
        travel_total = 0;
        crossings    = 0;
        turns        = 0;
        n_samples    = 0;
        prev_s       = 0;
        pivot_s      = 0;
    endfunction

    function automatic void fold_sample(logic signed [SAMPLE_W-1:0] s, logic fin);
        longint x, y, z, dx, sq, mag;
        stream_totals_t t;
        x  = longint'(s);
        y  = prev_s;
        z  = pivot_s;
        dx = x - y;
        if (x < amp_lo) amp_lo = x;
        if (x > amp_hi) amp_hi = x;
        amp_total = amp_total + x;
        if (amp_total > SUM_HI) amp_total = SUM_HI;
        if (amp_total < SUM_LO) amp_total = SUM_LO;
        sq = x * x;
        if (sq > SQ_MAX - energy_total) energy_total = SQ_MAX;
        else energy_total = energy_total + sq;
        if (n_samples >= 1)
        begin
            if (dx < step_lo) step_lo = dx;
            if (dx > step_hi) step_hi = dx;
        end
        mag = (dx < 0) ? -dx : dx;
        if (mag > ABS_MAX - travel_total) travel_total = ABS_MAX;
        else travel_total = travel_total + mag;
        if ((y < 0 && x >= 0) || (y > 0 && x <= 0)) crossings = sat_inc(crossings);
        if ((z < y && y > x) || (z > y && y < x)) turns = sat_inc(turns);
        if (x != y) pivot_s = y;
        prev_s    = x;
        n_samples = sat_inc(n_samples);
        if (fin)
        begin
            t.amp_min        = amp_lo[SAMPLE_W-1:0];
            t.amp_max        = amp_hi[SAMPLE_W-1:0];
            t.amp_sum        = amp_total[SUM_BITS-1:0];
            t.square_sum     = energy_total[SQ_BITS-1:0];
            t.step_min       = step_lo[SAMPLE_W:0];
            t.step_max       = step_hi[SAMPLE_W:0];
            t.abs_step_sum   = travel_total[ABS_BITS-1:0];
            t.zero_crossings = crossings[OUT_CNT_BITS-1:0];
            t.extrema_count  = turns[OUT_CNT_BITS-1:0];
            t.sample_count   = n_samples[OUT_CNT_BITS-1:0];
            totals_q.push_back(t);
            clear_stream();
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic report_field(string what, logic [63:0] exp_v, logic [63:0] got_v);
        if (got_v !== exp_v)
        begin
            if (error_count < 10)
                $display("mismatch %s: expected %h, got %h at %0t", what, exp_v, got_v, $realtime);
            error_count++;
        end
    endtask

    task automatic add_item(logic signed [SAMPLE_W-1:0] s, logic fin, bit drain);
        sample_item_t it;
        it.sample = s;
        it.last   = fin;
        it.drain  = drain;
        sample_queue.push_back(it);
        item_total++;
    endtask

    task automatic add_stream(int len, stream_kind_t kind, bit drain);
        int w;
        logic signed [SAMPLE_W-1:0] v;
        v = '0;
        for (int i = 0; i < len; i++)
        begin
            if (i == 0 || $urandom_range(0, 4) != 0)
            begin
                case (kind)
                    FULL_RANGE: v = SAMPLE_W'($urandom);
                    NEAR_ZERO:  v = SAMPLE_W'($urandom_range(0, 8) - 4);
                    WALK:
                    begin
                        w = int'(v) + $urandom_range(0, 4000) - 2000;
                        if (w > 32767) w = 32767;
                        if (w < -32768) w = -32768;
                        v = SAMPLE_W'(w);
                    end
                    default:
                    begin
                        case ($urandom_range(0, 4))
                            0: v = 16'sh7FFF;
                            1: v = 16'sh8000;
                            2: v = 16'sh0000;
                            3: v = 16'shFFFF;
                            default: v = 16'sh0001;
                        endcase
                    end
                endcase
            end
            add_item(v, i == len - 1, drain && i == 0);
        end
    endtask

    // sender: offers queued transactions, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_ch.valid <= 1'b0;
            samples_ch.sample <= '0;
            samples_ch.last <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            cycle_no <= cycle_no + 1'b1;
            if (samples_ch.valid && samples_ch.ready)
                fold_sample(samples_ch.sample, samples_ch.last);
            if (!samples_ch.valid || samples_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    samples_ch.valid <= 1'b0;
                end
                else if (sample_queue.size() > 0 &&
                         !(sample_queue[0].drain && totals_q.size() > 0))
                begin
                    next_item = sample_queue.pop_front();
                    samples_ch.valid <= 1'b1;
                    samples_ch.sample <= next_item.sample;
                    samples_ch.last <= next_item.last;
                    send_gap = calm ? 0 : pick_gap();
                end
                else
                    samples_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus two long hold-offs that back up the block
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_ch.ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (hold_left == 0 && holds_done < 2 && results_seen >= (holds_done == 0 ? 15 : 70))
            begin
                hold_left = LONG_HOLD;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stats_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                stats_ch.ready <= 1'b0;
            end
            else
            begin
                stats_ch.ready <= 1'b1;
                stall_left = (calm || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && stats_ch.valid && stats_ch.ready)
        begin
            results_seen++;
            if (totals_q.size() == 0)
            begin
                if (error_count < 10)
                    $display("unexpected stream totals at %0t", $realtime);
                error_count++;
            end
            else
            begin
                want = totals_q.pop_front();
                report_field("amp_min", 64'(want.amp_min), 64'(stats_ch.amp_min));
                report_field("amp_max", 64'(want.amp_max), 64'(stats_ch.amp_max));
                report_field("amp_sum", 64'(want.amp_sum), 64'(stats_ch.amp_sum));
                report_field("square_sum", 64'(want.square_sum), 64'(stats_ch.square_sum));
                report_field("step_min", 64'(want.step_min), 64'(stats_ch.step_min));
                report_field("step_max", 64'(want.step_max), 64'(stats_ch.step_max));
                report_field("abs_step_sum", 64'(want.abs_step_sum),
                             64'(stats_ch.abs_step_sum));
                report_field("zero_crossings", 64'(want.zero_crossings),
                             64'(stats_ch.zero_crossings));
                report_field("extrema_count", 64'(want.extrema_count),
                             64'(stats_ch.extrema_count));
                report_field("sample_count", 64'(want.sample_count),
                             64'(stats_ch.sample_count));
            end
        end
    end

    initial
    begin
        int len;
        int r;
        rst_n = 1'b0;
        samples_ch.valid = 1'b0;
        samples_ch.sample = '0;
        samples_ch.last = 1'b0;
        stats_ch.ready = 1'b0;
        clear_stream();

        // one-sample streams at both rails: step range stays empty
        add_item(16'sh8000, 1'b1, 1'b0);
        add_item(16'sh7FFF, 1'b1, 1'b0);
        // full-scale swings, largest steps both ways
        add_item(16'sh7FFF, 1'b0, 1'b0);
        add_item(16'sh8000, 1'b0, 1'b0);
        add_item(16'sh7FFF, 1'b0, 1'b0);
        add_item(16'sh8000, 1'b1, 1'b0);
        // crossings onto and away from zero
        add_item(-16'sd5, 1'b0, 1'b1);
        add_item(16'sd0, 1'b0, 1'b0);
        add_item(16'sd3, 1'b0, 1'b0);
        add_item(16'sd0, 1'b0, 1'b0);
        add_item(-16'sd2, 1'b0, 1'b0);
        add_item(16'sd0, 1'b0, 1'b0);
        add_item(16'sd0, 1'b1, 1'b0);
        // plateaus at a peak and at a trough
        add_item(16'sd1, 1'b0, 1'b0);
        add_item(16'sd4, 1'b0, 1'b0);
        add_item(16'sd4, 1'b0, 1'b0);
        add_item(16'sd4, 1'b0, 1'b0);
        add_item(16'sd2, 1'b0, 1'b0);
        add_item(16'sd2, 1'b0, 1'b0);
        add_item(16'sd6, 1'b1, 1'b0);
        // alternating bit patterns
        add_item(16'sh5555, 1'b0, 1'b0);
        add_item(16'shAAAA, 1'b0, 1'b0);
        add_item(16'sh5555, 1'b1, 1'b0);

        while (item_total < TARGET_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 80) len = $urandom_range(1, 12);
            else if (r < 96) len = $urandom_range(13, 60);
            else len = $urandom_range(100, 250);
            add_stream(len, stream_kind_t'($urandom_range(0, 3)), $urandom_range(0, 14) == 0);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (sample_queue.size() > 0 || samples_ch.valid !== 1'b0)
            @(posedge clk);
        while (totals_q.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/sss_pkg.sv
rtl/core/sss_sample_if.sv
rtl/core/sss_stats_if.sv
rtl/core/sample_stream_statistics.sv
bench/tb_sample_stream_statistics.sv
